FILE: design/whitelisted_mailbox_fifo_defines.svh
// Assertion helpers used by the checker file.
`ifndef WHITELISTED_MAILBOX_FIFO_DEFINES_SVH
`define WHITELISTED_MAILBOX_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox fifo check failed");

// Next-cycle implication, disabled while in reset.
`define MBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox fifo check failed");

`endif

FILE: design/mbf_pkg.sv
package mbf_pkg;

    localparam int FIFO_DEPTH     = 16;
    localparam int WHITELIST_BITS = 64;
    localparam int MAX_SLOT_BYTES = 8;

    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int DATA_W = 64;
    localparam int SID_W  = 6;
    localparam int CTR_W  = 32;
    localparam int ENTRY_W = DATA_W + SID_W;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 208;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITELIST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN  = 8'd1;

    localparam logic [3:0] SLOT_LEN_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_INVALID_ARG     = 3'd1,
        ST_BAD_ID          = 3'd2,
        ST_NOT_WHITELISTED = 3'd3,
        ST_FULL            = 3'd4,
        ST_EMPTY           = 3'd5
    } status_t;

    // Keep the low nbytes bytes of a payload word.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] nbytes);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            if (4'(i) < nbytes)
                mask[i*8 +: 8] = 8'hFF;
        end
        return mask;
    endfunction

endpackage

FILE: design/mbf_ram.sv
module mbf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/whitelisted_mailbox_fifo.sv
// Channel  | Direction | Word layout (low bit first)
// s_*      | in        | operation[1:0] source_vm[17:2] payload_data[81:18]
//          |           | payload_length[85:82], zero fill to 88
// m_*      | out       | status, message_data, message_sender, accepted_count,
//          |           | perm_reject_count, full_reject_count, receive_count
// cfg_*    | in        | cfg_index selects register, cfg_data carries value
//
// Each item: read the head entry from the queue memory, then decide, update
// pointers and counters and write the memory. Reset clears pointers, fill
// count, counters and whitelist and sets the slot length to 8; queue memory,
// held input and result payload are not cleared. A result waits in the output
// register while the next word is accepted; execute holds until it is free.
module whitelisted_mailbox_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // operation, source_vm, payload_data, payload_length, zero fill
    input  logic [mbf_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, message_data, message_sender, accepted_count, perm_reject_count,
    // full_reject_count, receive_count, zero fill
    output logic [mbf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                        cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [63:0] whitelist_reg;
    logic [3:0]  slot_len_reg;

    // Queue control and counters
    logic [mbf_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mbf_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mbf_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [mbf_pkg::CTR_W-1:0] acc_ctr_reg, acc_ctr_next;
    logic [mbf_pkg::CTR_W-1:0] perm_ctr_reg, perm_ctr_next;
    logic [mbf_pkg::CTR_W-1:0] full_ctr_reg, full_ctr_next;
    logic [mbf_pkg::CTR_W-1:0] rcv_ctr_reg, rcv_ctr_next;

    // Held input word
    mbf_pkg::op_t                op_reg;
    logic [15:0]                 sid_reg;
    logic [mbf_pkg::DATA_W-1:0]  data_reg;
    logic [3:0]                  len_reg;

    // Output register
    logic                        m_valid_reg;
    mbf_pkg::status_t            status_reg, status_next;
    logic [mbf_pkg::DATA_W-1:0]  mdata_reg, mdata_next;
    logic [mbf_pkg::SID_W-1:0]   msender_reg, msender_next;

    // Memory interface
    logic                        mem_wr_en;
    logic [mbf_pkg::ENTRY_W-1:0] mem_wr_data;
    logic [mbf_pkg::ENTRY_W-1:0] mem_rd_data;

    logic s_accept;
    logic commit;
    logic len_bad;
    logic id_bad;
    logic fifo_full;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign commit    = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign len_bad   = (slot_len_reg == 4'd0)
                    || (slot_len_reg > 4'(mbf_pkg::MAX_SLOT_BYTES))
                    || (len_reg != slot_len_reg);
    assign id_bad    = (sid_reg >= 16'(mbf_pkg::WHITELIST_BITS));
    assign fifo_full = (fill_reg == mbf_pkg::CNT_W'(mbf_pkg::FIFO_DEPTH));

    assign mem_wr_data = {sid_reg[mbf_pkg::SID_W-1:0],
                          data_reg & mbf_pkg::byte_mask(slot_len_reg)};

    mbf_ram #(
        .WIDTH  (mbf_pkg::ENTRY_W),
        .DEPTH  (mbf_pkg::FIFO_DEPTH),
        .ADDR_W (mbf_pkg::PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (mem_wr_data),
        .rd_en   (s_accept),
        .rd_addr (rd_ptr_reg),
        .rd_data (mem_rd_data)
    );

    // Advance a queue pointer with wrap
    function automatic logic [mbf_pkg::PTR_W-1:0] ptr_inc(
        input logic [mbf_pkg::PTR_W-1:0] p);
        logic [mbf_pkg::PTR_W-1:0] r;
        if (p == mbf_pkg::PTR_W'(mbf_pkg::FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // Decide the item and build the next state
    always_comb
    begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        acc_ctr_next  = acc_ctr_reg;
        perm_ctr_next = perm_ctr_reg;
        full_ctr_next = full_ctr_reg;
        rcv_ctr_next  = rcv_ctr_reg;
        status_next   = mbf_pkg::ST_OK;
        mdata_next    = '0;
        msender_next  = '0;
        mem_wr_en     = 1'b0;

        case (op_reg)
            mbf_pkg::OP_SEND:
            begin
                if (len_bad)
                    status_next = mbf_pkg::ST_INVALID_ARG;
                else if (id_bad)
                    status_next = mbf_pkg::ST_BAD_ID;
                else if (!whitelist_reg[sid_reg[mbf_pkg::SID_W-1:0]])
                begin
                    status_next   = mbf_pkg::ST_NOT_WHITELISTED;
                    perm_ctr_next = perm_ctr_reg + 1'b1;
                end
                else if (fifo_full)
                begin
                    status_next   = mbf_pkg::ST_FULL;
                    full_ctr_next = full_ctr_reg + 1'b1;
                end
                else
                begin
                    mem_wr_en    = commit;
                    wr_ptr_next  = ptr_inc(wr_ptr_reg);
                    fill_next    = fill_reg + 1'b1;
                    acc_ctr_next = acc_ctr_reg + 1'b1;
                end
            end
            mbf_pkg::OP_RECEIVE, mbf_pkg::OP_PEEK:
            begin
                if (fill_reg == '0)
                    status_next = mbf_pkg::ST_EMPTY;
                else
                begin
                    mdata_next   = mem_rd_data[mbf_pkg::DATA_W-1:0];
                    msender_next = mem_rd_data[mbf_pkg::ENTRY_W-1:mbf_pkg::DATA_W];
                    if (op_reg == mbf_pkg::OP_RECEIVE)
                    begin
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        fill_next    = fill_reg - 1'b1;
                        rcv_ctr_next = rcv_ctr_reg + 1'b1;
                    end
                end
            end
            mbf_pkg::OP_FLUSH:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                fill_next   = '0;
            end
            default:
            begin
                status_next = mbf_pkg::ST_OK;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            whitelist_reg <= '0;
            slot_len_reg  <= mbf_pkg::SLOT_LEN_RESET;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            acc_ctr_reg   <= '0;
            perm_ctr_reg  <= '0;
            full_ctr_reg  <= '0;
            rcv_ctr_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mbf_pkg::CFG_WHITELIST)
                    whitelist_reg <= cfg_data;
                else if (cfg_index == mbf_pkg::CFG_SLOT_LEN)
                    slot_len_reg <= cfg_data[3:0];
            end
            if (commit)
            begin
                rd_ptr_reg   <= rd_ptr_next;
                wr_ptr_reg   <= wr_ptr_next;
                fill_reg     <= fill_next;
                acc_ctr_reg  <= acc_ctr_next;
                perm_ctr_reg <= perm_ctr_next;
                full_ctr_reg <= full_ctr_next;
                rcv_ctr_reg  <= rcv_ctr_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Hold the input word and load the result payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= mbf_pkg::op_t'(s_tdata[1:0]);
            sid_reg  <= s_tdata[17:2];
            data_reg <= s_tdata[81:18];
            len_reg  <= s_tdata[85:82];
        end
        if (commit)
        begin
            status_reg  <= status_next;
            mdata_reg   <= mdata_next;
            msender_reg <= msender_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, rcv_ctr_reg, full_ctr_reg, perm_ctr_reg, acc_ctr_reg,
                       msender_reg, mdata_reg, status_reg};

endmodule

FILE: design/mbf_checker.sv
`include "whitelisted_mailbox_fifo_defines.svh"

module mbf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mbf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [mbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]                   cfg_data
);

    logic s_word;
    logic m_stall;
    logic m_not_ok;
    logic m_msg_zero;
    logic s_idle_word;

    assign s_word      = s_tvalid && s_tready;
    assign m_stall     = m_tvalid && !m_tready;
    assign m_not_ok    = m_tvalid && (m_tdata[2:0] != mbf_pkg::ST_OK);
    assign m_msg_zero  = (m_tdata[66:3] == '0) && (m_tdata[72:67] == '0);
    assign s_idle_word = cfg_valid && cfg_ready && (cfg_index != '0) && (cfg_data != '0);

    // A stalled result word holds its contents
    `MBF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_stall, m_tvalid && $stable(m_tdata))

    // One item in flight: no word is taken right after one is accepted
    `MBF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_word, !s_tready)

    // Failed or empty answers carry no message
    `MBF_ASSERT_NOW(a_err_no_msg, clk, rst_n, m_not_ok, m_msg_zero)

    // Fill bits of the result word stay zero
    `MBF_ASSERT_NOW(a_out_fill, clk, rst_n, m_tvalid || s_idle_word,
        (m_tdata[207:201] == '0) || !m_tvalid)

endmodule

bind whitelisted_mailbox_fifo mbf_checker u_mbf_checker (.*);
